>>> design/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types, constants and helpers of the slotted page directory.
// ----------------------------------------------------------------------------
package spd_pkg;

   // page geometry
   localparam int PAGE_BYTES   = 8192;
   localparam int MAX_SLOTS    = 2048;
   localparam int ALIGN_BYTES  = 8;
   localparam int HEADER_BYTES = 8;
   localparam int SLOT_BYTES   = 4;

   // field and register widths
   localparam int BND_W    = 14;
   localparam int CNT_W    = 12;
   localparam int ADDR_W   = 11;
   localparam int SIZE_W   = 14;
   localparam int SLOT_W   = 11;
   localparam int OFF_W    = 13;
   localparam int FREE_W   = 14;
   localparam int SPEC_W   = 13;
   localparam int ACT_W    = 3;
   localparam int FLAG_W   = 2;
   localparam int STS_W    = 2;
   localparam int IDX_W    = 1;

   // actions
   localparam logic [ACT_W-1:0] ACT_INIT    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ADD     = 3'd1;
   localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_COMPACT = 3'd3;
   localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd4;

   // result status codes
   localparam logic [STS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STS_W-1:0] STS_OVERWRITE = 2'd1;
   localparam logic [STS_W-1:0] STS_NO_ROOM   = 2'd2;
   localparam logic [STS_W-1:0] STS_INVALID   = 2'd3;

   // configuration register indexes
   localparam logic [IDX_W-1:0] REG_SHUFFLE = 1'd0;
   localparam logic [IDX_W-1:0] REG_SPECIAL = 1'd1;

   typedef struct packed {
      logic [BND_W-1:0]  off;
      logic [SIZE_W-1:0] len;
      logic [FLAG_W-1:0] flags;
   } dir_entry_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_INIT,
      CMD_SRCH_RD,
      CMD_SRCH_CK,
      CMD_SRCH_MISS,
      CMD_CHK_RD,
      CMD_CHK_CK,
      CMD_ROOM,
      CMD_SH_RD,
      CMD_SH_WR,
      CMD_ADD_WR,
      CMD_DEL_BAD,
      CMD_DEL_RD,
      CMD_DEL_CK,
      CMD_DEL_MRD,
      CMD_DEL_MWR,
      CMD_DEL_FIN,
      CMD_CLR_RD,
      CMD_CLR_WR,
      CMD_CMP_INIT,
      CMD_SEL_RD,
      CMD_SEL_CK,
      CMD_SEL_END,
      CMD_CP_RD,
      CMD_CP_WR,
      CMD_CMP_FIN,
      CMD_OUT
   } dp_cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             n_zero;
      logic             ovw_mode;
      logic             del_invalid;
      logic             idx_end;
      logic             del_end;
      logic             srch_hit;
      logic             ovw_bad;
      logic             room_fail;
      logic             need_shift;
      logic             idx_eq_n;
      logic             best_found;
      logic             rsp_busy;
   } dp_status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_INIT,
      S_SRCH,
      S_SRCH_CK,
      S_CHK_RD,
      S_CHK_CK,
      S_ROOM,
      S_SH_RD,
      S_SH_WR,
      S_ADD_WR,
      S_DEL_RD,
      S_DEL_CK,
      S_DEL_LOOP,
      S_DEL_MRD,
      S_DEL_MWR,
      S_DEL_FIN,
      S_CLR_LOOP,
      S_CLR_RD,
      S_CLR_WR,
      S_SEL_LOOP,
      S_SEL_RD,
      S_SEL_CK,
      S_SEL_END,
      S_CP_LOOP,
      S_CP_RD,
      S_CP_WR,
      S_CMP_FIN,
      S_OUT
   } ctrl_state_type;

   // round a length up to the item alignment
   function automatic logic [SIZE_W:0] align_up(input logic [SIZE_W-1:0] x);
      logic [SIZE_W:0] s;
      s = {1'b0, x} + (SIZE_W+1)'(ALIGN_BYTES - 1);
      return s & ~((SIZE_W+1)'(ALIGN_BYTES - 1));
   endfunction

   // add two offsets, saturating at the page end
   function automatic logic [BND_W-1:0] sat_add(input logic [BND_W-1:0] a,
                                                input logic [SIZE_W:0]  b);
      logic [BND_W+1:0] s;
      s = {2'b00, a} + {1'b0, b};
      return (s > (BND_W+2)'(PAGE_BYTES)) ? BND_W'(PAGE_BYTES) : s[BND_W-1:0];
   endfunction

endpackage

>>> design/slotted_page_directory.sv
// Steps to the result: a query goes to the output; init sets the bounds; add searches for
// a free slot or checks the overwrite target, checks room, shifts and writes; delete
// reads, checks, moves entries; compact clears, scans per used entry plus once, copies.
// Throughput: one item at a time; the next beat is taken once the result is registered.
// Reset: synchronous, active high; bounds return to an empty page, shuffle mode on,
// no special area. Directory entries hold no reset value.
// ----------------------------------------------------------------------------
// slotted_page_directory
// Slot directory and free-space bounds of one page: init, add, delete, compact.
// ----------------------------------------------------------------------------
module slotted_page_directory (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [spd_pkg::IDX_W-1:0]   csr_index,
   input  logic [spd_pkg::SPEC_W-1:0]  csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // item_size [13:0], slot_number [24:14], item_flags [26:25]
   input  logic [31:0]                 req_tdata,
   // action [2:0]
   input  logic [2:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // result_slot [10:0], item_offset [23:11], free_bytes [37:24], slot_count [48:38]
   output logic [55:0]                 rsp_tdata,
   // status [1:0]
   output logic [1:0]                  rsp_tuser
);
   import spd_pkg::*;

   dp_cmd_type        dp_cmd;
   dp_status_type     dp_status;
   logic [SLOT_W-1:0] rsp_slot, rsp_cnt;
   logic [OFF_W-1:0]  rsp_off;
   logic [FREE_W-1:0] rsp_free;

   spd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   spd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_action      (req_tuser),
      .req_item_size   (req_tdata[13:0]),
      .req_slot_number (req_tdata[24:14]),
      .req_item_flags  (req_tdata[26:25]),
      .rsp_tready      (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_status      (rsp_tuser),
      .rsp_result_slot (rsp_slot),
      .rsp_item_offset (rsp_off),
      .rsp_free_bytes  (rsp_free),
      .rsp_slot_count  (rsp_cnt)
   );

   // pack the result beat
   assign rsp_tdata = {7'd0, rsp_cnt, rsp_free, rsp_off, rsp_slot};

endmodule

>>> design/spd_ctrl.sv
// ----------------------------------------------------------------------------
// spd_ctrl
// Sequencer of the slot directory: walks each action through its passes.
// ----------------------------------------------------------------------------
module spd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  spd_pkg::dp_status_type dp_status,
   output spd_pkg::dp_cmd_type    dp_cmd
);
   import spd_pkg::*;

   ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      dp_cmd     = CMD_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dp_cmd   = CMD_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (dp_status.action)
               ACT_INIT:    state_in = S_INIT;
               ACT_ADD: begin
                  if (dp_status.n_zero) begin
                     state_in = S_SRCH;
                  end else if (dp_status.ovw_mode) begin
                     state_in = S_CHK_RD;
                  end else begin
                     state_in = S_ROOM;
                  end
               end
               ACT_DELETE: begin
                  if (dp_status.del_invalid) begin
                     dp_cmd   = CMD_DEL_BAD;
                     state_in = S_OUT;
                  end else begin
                     state_in = S_DEL_RD;
                  end
               end
               ACT_COMPACT: state_in = S_CLR_LOOP;
               default:     state_in = S_OUT;
            endcase
         end
         S_INIT: begin
            dp_cmd   = CMD_INIT;
            state_in = S_OUT;
         end
         S_SRCH: begin
            if (dp_status.idx_end) begin
               dp_cmd   = CMD_SRCH_MISS;
               state_in = S_ROOM;
            end else begin
               dp_cmd   = CMD_SRCH_RD;
               state_in = S_SRCH_CK;
            end
         end
         S_SRCH_CK: begin
            dp_cmd   = CMD_SRCH_CK;
            state_in = dp_status.srch_hit ? S_ROOM : S_SRCH;
         end
         S_CHK_RD: begin
            dp_cmd   = CMD_CHK_RD;
            state_in = S_CHK_CK;
         end
         S_CHK_CK: begin
            dp_cmd   = CMD_CHK_CK;
            state_in = dp_status.ovw_bad ? S_OUT : S_ROOM;
         end
         S_ROOM: begin
            dp_cmd = CMD_ROOM;
            if (dp_status.room_fail) begin
               state_in = S_OUT;
            end else if (dp_status.need_shift) begin
               state_in = S_SH_RD;
            end else begin
               state_in = S_ADD_WR;
            end
         end
         S_SH_RD: begin
            dp_cmd   = CMD_SH_RD;
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            dp_cmd   = CMD_SH_WR;
            state_in = dp_status.idx_eq_n ? S_ADD_WR : S_SH_RD;
         end
         S_ADD_WR: begin
            dp_cmd   = CMD_ADD_WR;
            state_in = S_OUT;
         end
         S_DEL_RD: begin
            dp_cmd   = CMD_DEL_RD;
            state_in = S_DEL_CK;
         end
         S_DEL_CK: begin
            dp_cmd   = CMD_DEL_CK;
            state_in = S_DEL_LOOP;
         end
         S_DEL_LOOP: begin
            state_in = dp_status.del_end ? S_DEL_FIN : S_DEL_MRD;
         end
         S_DEL_MRD: begin
            dp_cmd   = CMD_DEL_MRD;
            state_in = S_DEL_MWR;
         end
         S_DEL_MWR: begin
            dp_cmd   = CMD_DEL_MWR;
            state_in = S_DEL_LOOP;
         end
         S_DEL_FIN: begin
            dp_cmd   = CMD_DEL_FIN;
            state_in = S_OUT;
         end
         S_CLR_LOOP: begin
            if (dp_status.idx_end) begin
               dp_cmd   = CMD_CMP_INIT;
               state_in = S_SEL_LOOP;
            end else begin
               state_in = S_CLR_RD;
            end
         end
         S_CLR_RD: begin
            dp_cmd   = CMD_CLR_RD;
            state_in = S_CLR_WR;
         end
         S_CLR_WR: begin
            dp_cmd   = CMD_CLR_WR;
            state_in = S_CLR_LOOP;
         end
         S_SEL_LOOP: begin
            state_in = dp_status.idx_end ? S_SEL_END : S_SEL_RD;
         end
         S_SEL_RD: begin
            dp_cmd   = CMD_SEL_RD;
            state_in = S_SEL_CK;
         end
         S_SEL_CK: begin
            dp_cmd   = CMD_SEL_CK;
            state_in = S_SEL_LOOP;
         end
         S_SEL_END: begin
            dp_cmd   = CMD_SEL_END;
            state_in = dp_status.best_found ? S_SEL_LOOP : S_CP_LOOP;
         end
         S_CP_LOOP: begin
            state_in = dp_status.idx_end ? S_CMP_FIN : S_CP_RD;
         end
         S_CP_RD: begin
            dp_cmd   = CMD_CP_RD;
            state_in = S_CP_WR;
         end
         S_CP_WR: begin
            dp_cmd   = CMD_CP_WR;
            state_in = S_CP_LOOP;
         end
         S_CMP_FIN: begin
            dp_cmd   = CMD_CMP_FIN;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!dp_status.rsp_busy) begin
               dp_cmd   = CMD_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // an accepted beat always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_DISPATCH))
      else $error("accepted beat did not start work");

   // a result leaves once the output register is free
   a_out_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !dp_status.rsp_busy) |=> (state_ff == S_IDLE))
      else $error("result not handed to output register");

   // the shift pass ends at the insert slot
   a_shift_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SH_WR && dp_status.idx_eq_n) |=> (state_ff == S_ADD_WR))
      else $error("shift pass overran insert slot");

endmodule

>>> design/spd_datapath.sv
// ----------------------------------------------------------------------------
// spd_datapath
// Slot directory memory, free-space bounds, index and selection registers.
// ----------------------------------------------------------------------------
module spd_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  spd_pkg::dp_cmd_type              dp_cmd,
   output spd_pkg::dp_status_type           dp_status,
   input  logic                             csr_we,
   input  logic [spd_pkg::IDX_W-1:0]        csr_index,
   input  logic [spd_pkg::SPEC_W-1:0]       csr_wdata,
   input  logic [spd_pkg::ACT_W-1:0]        req_action,
   input  logic [spd_pkg::SIZE_W-1:0]       req_item_size,
   input  logic [spd_pkg::SLOT_W-1:0]       req_slot_number,
   input  logic [spd_pkg::FLAG_W-1:0]       req_item_flags,
   input  logic                             rsp_tready,
   output logic                             rsp_valid,
   output logic [spd_pkg::STS_W-1:0]        rsp_status,
   output logic [spd_pkg::SLOT_W-1:0]       rsp_result_slot,
   output logic [spd_pkg::OFF_W-1:0]        rsp_item_offset,
   output logic [spd_pkg::FREE_W-1:0]       rsp_free_bytes,
   output logic [spd_pkg::SLOT_W-1:0]       rsp_slot_count
);
   import spd_pkg::*;

   localparam logic [BND_W-1:0] MAX_SP =
      BND_W'((PAGE_BYTES - HEADER_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES);

   // directory and compaction offset stores
   dir_entry_type     dir_mem [MAX_SLOTS];
   logic [BND_W-1:0]  new_off_mem [MAX_SLOTS];
   dir_entry_type     rd_data_ff;
   logic [BND_W-1:0]  new_off_rd_ff;
   logic              rd_en, wr_en, no_wr_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr, no_wr_addr;
   dir_entry_type     wr_data;
   logic [BND_W-1:0]  no_wr_data;

   // configuration
   logic              shuffle_mode_ff;
   logic [SPEC_W-1:0] special_bytes_ff;

   // page bounds
   logic [BND_W-1:0]  lower_ff, upper_ff, special_ff;

   // latched request
   logic [ACT_W-1:0]  act_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [FLAG_W-1:0] flags_ff;
   logic              shuffled_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  idx_ff;

   // result fields
   logic [STS_W-1:0]  status_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic [OFF_W-1:0]  res_off_ff;

   // add staging
   logic [BND_W:0]    newlow_ff;
   logic [BND_W-1:0]  newup_ff;

   // delete staging
   logic [SIZE_W:0]   del_sz_ff;
   logic [BND_W-1:0]  del_loc_ff;

   // compaction selection
   logic [BND_W-1:0]  up_ff;
   logic              have_last_ff;
   logic [CNT_W-1:0]  last_idx_ff;
   logic [BND_W-1:0]  last_off_ff;
   logic              best_found_ff;
   logic [CNT_W-1:0]  best_idx_ff;
   logic [BND_W-1:0]  best_off_ff;
   logic [SIZE_W-1:0] best_len_ff;

   // output register
   logic              rsp_valid_ff;
   logic [STS_W-1:0]  rsp_status_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [OFF_W-1:0]  rsp_off_ff;
   logic [FREE_W-1:0] rsp_free_ff;
   logic [SLOT_W-1:0] rsp_cnt_ff;

   // derived values
   logic [CNT_W-1:0]  cur_cnt;
   logic [BND_W:0]    low_plus;
   logic [FREE_W-1:0] free_now;
   logic [CNT_W-1:0]  n_m1, idx_m1, idx_p1, limit, del_src;
   logic [SIZE_W:0]   asz, sel_asz, sp_al;
   logic [BND_W:0]    newlow;
   logic [BND_W-1:0]  newup, up_next, sp_cl;
   logic              room_fail, sel_take, ovw_bad, srch_hit;
   logic [BND_W:0]    count_span;

   // directory count from the lower bound
   always_comb begin
      logic [BND_W-1:0] span;
      span = (lower_ff >= BND_W'(HEADER_BYTES)) ? lower_ff - BND_W'(HEADER_BYTES) : '0;
      if ((span / SLOT_BYTES) > BND_W'(MAX_SLOTS)) begin
         cur_cnt = CNT_W'(MAX_SLOTS);
      end else begin
         cur_cnt = CNT_W'(span / SLOT_BYTES);
      end
   end

   // free space after the bounds
   assign low_plus = {1'b0, lower_ff} + (BND_W+1)'(SLOT_BYTES);
   assign free_now = ({1'b0, upper_ff} >= low_plus) ?
                     FREE_W'({1'b0, upper_ff} - low_plus) : '0;

   assign n_m1    = n_ff - CNT_W'(1);
   assign idx_m1  = idx_ff - CNT_W'(1);
   assign idx_p1  = idx_ff + CNT_W'(1);
   assign limit   = cnt_ff + CNT_W'(1);
   assign del_src = (idx_ff < n_m1) ? idx_ff : idx_p1;

   assign ovw_bad  = rd_data_ff.flags[0] || (rd_data_ff.len != '0);
   assign srch_hit = !rd_data_ff.flags[0] && (rd_data_ff.len == '0);

   // room check for an add
   always_comb begin
      if (n_ff > limit) begin
         newlow = (BND_W+1)'(HEADER_BYTES) + (BND_W+1)'({n_ff, 2'b00});
      end else if (n_ff == limit || shuffled_ff) begin
         newlow = low_plus;
      end else begin
         newlow = {1'b0, lower_ff};
      end
      asz        = align_up(size_ff);
      newup      = upper_ff - asz[BND_W-1:0];
      count_span = newlow - (BND_W+1)'(HEADER_BYTES);
      room_fail  = (asz > {1'b0, upper_ff}) || (newlow > {1'b0, newup}) ||
                   (newlow < (BND_W+1)'(HEADER_BYTES)) ||
                   ((count_span / SLOT_BYTES) > (BND_W+1)'(MAX_SLOTS));
   end

   // compaction candidate and placement
   always_comb begin
      logic after_last, better;
      after_last = !have_last_ff || (rd_data_ff.off < last_off_ff) ||
                   (rd_data_ff.off == last_off_ff && idx_ff > last_idx_ff);
      better     = !best_found_ff || (rd_data_ff.off > best_off_ff);
      sel_take   = rd_data_ff.flags[0] && after_last && better;
      sel_asz    = align_up(best_len_ff);
      up_next    = (sel_asz > {1'b0, up_ff}) ? '0 : up_ff - sel_asz[BND_W-1:0];
   end

   // special area at init
   always_comb begin
      sp_al = align_up({1'b0, special_bytes_ff});
      sp_cl = (sp_al > {1'b0, MAX_SP}) ? MAX_SP : sp_al[BND_W-1:0];
   end

   // memory port selection
   always_comb begin
      rd_en      = 1'b0;
      rd_addr    = idx_ff[ADDR_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = idx_ff[ADDR_W-1:0];
      wr_data    = rd_data_ff;
      no_wr_en   = 1'b0;
      no_wr_addr = best_idx_ff[ADDR_W-1:0];
      no_wr_data = up_next;
      case (dp_cmd)
         CMD_SRCH_RD, CMD_SEL_RD, CMD_CLR_RD, CMD_CP_RD: rd_en = 1'b1;
         CMD_CHK_RD, CMD_DEL_RD: begin
            rd_en   = 1'b1;
            rd_addr = n_m1[ADDR_W-1:0];
         end
         CMD_SH_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_m1[ADDR_W-1:0];
         end
         CMD_DEL_MRD: begin
            rd_en   = 1'b1;
            rd_addr = del_src[ADDR_W-1:0];
         end
         CMD_SH_WR: wr_en = 1'b1;
         CMD_ADD_WR: begin
            wr_en         = 1'b1;
            wr_addr       = n_m1[ADDR_W-1:0];
            wr_data.off   = newup_ff;
            wr_data.len   = size_ff;
            wr_data.flags = flags_ff;
         end
         CMD_DEL_MWR: begin
            wr_en = 1'b1;
            if (rd_data_ff.off <= del_loc_ff) begin
               wr_data.off = sat_add(rd_data_ff.off, del_sz_ff);
            end
         end
         CMD_CLR_WR: begin
            wr_en       = !rd_data_ff.flags[0];
            wr_data.len = '0;
         end
         CMD_CP_WR: begin
            wr_en       = rd_data_ff.flags[0];
            wr_data.off = new_off_rd_ff;
         end
         CMD_SEL_END: no_wr_en = best_found_ff;
         default: ;
      endcase
   end

   // directory memories
   always_ff @(posedge clock) begin
      if (wr_en) begin
         dir_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= dir_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (no_wr_en) begin
         new_off_mem[no_wr_addr] <= no_wr_data;
      end
      if (rd_en) begin
         new_off_rd_ff <= new_off_mem[rd_addr];
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         shuffle_mode_ff  <= 1'b1;
         special_bytes_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SHUFFLE: shuffle_mode_ff  <= csr_wdata[0];
            REG_SPECIAL: special_bytes_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // bounds and work registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff   <= BND_W'(HEADER_BYTES);
         upper_ff   <= BND_W'(PAGE_BYTES);
         special_ff <= BND_W'(PAGE_BYTES);
      end else begin
         case (dp_cmd)
            CMD_LOAD: begin
               act_ff      <= req_action;
               size_ff     <= req_item_size;
               n_ff        <= {1'b0, req_slot_number};
               flags_ff    <= req_item_flags;
               shuffled_ff <= (req_slot_number != '0) && shuffle_mode_ff;
               cnt_ff      <= cur_cnt;
               idx_ff      <= '0;
               status_ff   <= STS_OK;
               res_slot_ff <= '0;
               res_off_ff  <= '0;
            end
            CMD_INIT: begin
               lower_ff   <= BND_W'(HEADER_BYTES);
               upper_ff   <= BND_W'(PAGE_BYTES) - sp_cl;
               special_ff <= BND_W'(PAGE_BYTES) - sp_cl;
            end
            CMD_SRCH_CK: begin
               if (srch_hit) begin
                  n_ff <= idx_p1;
               end else begin
                  idx_ff <= idx_p1;
               end
            end
            CMD_SRCH_MISS: n_ff <= limit;
            CMD_CHK_CK: begin
               if (ovw_bad) begin
                  status_ff <= STS_OVERWRITE;
               end
            end
            CMD_ROOM: begin
               if (room_fail) begin
                  status_ff <= STS_NO_ROOM;
               end
               newlow_ff <= newlow;
               newup_ff  <= newup;
               idx_ff    <= cnt_ff;
            end
            CMD_SH_WR: idx_ff <= idx_m1;
            CMD_ADD_WR: begin
               lower_ff    <= newlow_ff[BND_W-1:0];
               upper_ff    <= newup_ff;
               res_slot_ff <= n_ff[SLOT_W-1:0];
               res_off_ff  <= newup_ff[OFF_W-1:0];
            end
            CMD_DEL_BAD: status_ff <= STS_INVALID;
            CMD_DEL_CK: begin
               del_sz_ff  <= align_up(rd_data_ff.len);
               del_loc_ff <= rd_data_ff.off;
               idx_ff     <= '0;
            end
            CMD_DEL_MWR, CMD_CLR_WR, CMD_CP_WR: idx_ff <= idx_p1;
            CMD_DEL_FIN: begin
               upper_ff <= sat_add(upper_ff, del_sz_ff);
               lower_ff <= lower_ff - BND_W'(SLOT_BYTES);
            end
            CMD_CMP_INIT: begin
               up_ff         <= special_ff;
               have_last_ff  <= 1'b0;
               best_found_ff <= 1'b0;
               idx_ff        <= '0;
            end
            CMD_SEL_CK: begin
               if (sel_take) begin
                  best_found_ff <= 1'b1;
                  best_idx_ff   <= idx_ff;
                  best_off_ff   <= rd_data_ff.off;
                  best_len_ff   <= rd_data_ff.len;
               end
               idx_ff <= idx_p1;
            end
            CMD_SEL_END: begin
               if (best_found_ff) begin
                  up_ff        <= up_next;
                  have_last_ff <= 1'b1;
                  last_idx_ff  <= best_idx_ff;
                  last_off_ff  <= best_off_ff;
               end
               best_found_ff <= 1'b0;
               idx_ff        <= '0;
            end
            CMD_CMP_FIN: upper_ff <= up_ff;
            default: ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd == CMD_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd == CMD_OUT) begin
         rsp_status_ff <= status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_off_ff    <= res_off_ff;
         rsp_free_ff   <= free_now;
         rsp_cnt_ff    <= cur_cnt[SLOT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_item_offset = rsp_off_ff;
   assign rsp_free_bytes  = rsp_free_ff;
   assign rsp_slot_count  = rsp_cnt_ff;

   // status to the sequencer
   always_comb begin
      dp_status.action      = act_ff;
      dp_status.n_zero      = (n_ff == '0);
      dp_status.ovw_mode    = (n_ff != '0) && !shuffled_ff;
      dp_status.del_invalid = (n_ff == '0) || (n_ff > cnt_ff);
      dp_status.idx_end     = (idx_ff == cnt_ff);
      dp_status.del_end     = (idx_p1 >= cnt_ff);
      dp_status.srch_hit    = srch_hit;
      dp_status.ovw_bad     = ovw_bad;
      dp_status.room_fail   = room_fail;
      dp_status.need_shift  = shuffled_ff && (n_ff < limit);
      dp_status.idx_eq_n    = (idx_ff == n_ff);
      dp_status.best_found  = best_found_ff;
      dp_status.rsp_busy    = rsp_valid_ff && !rsp_tready;
   end

endmodule

>>> tb/page_directory_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_directory_checker
// Watches the request, result and register ports of the slotted page
// directory, keeps its own copy of the page state, predicts each result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module page_directory_checker
   import spd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [IDX_W-1:0]     csr_index,
   input  logic [SPEC_W-1:0]    csr_wdata,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [31:0]          req_tdata,
   input  logic [2:0]           req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [55:0]          rsp_tdata,
   input  logic [1:0]           rsp_tuser,
   output int                   fail_count,
   output int                   pend_count,
   output int                   page_count,
   output int                   checked_count,
   output logic [MAX_SLOTS-1:0] dir_written
);

   typedef struct {
      logic [STS_W-1:0]  status;
      logic [SLOT_W-1:0] slot;
      logic [OFF_W-1:0]  offset;
      logic [FREE_W-1:0] free;
      logic [SLOT_W-1:0] count;
   } page_answer_type;

   // shadow page state
   dir_entry_type     dir [MAX_SLOTS];
   logic [BND_W-1:0]  lower_b;
   logic [BND_W-1:0]  upper_b;
   logic [BND_W-1:0]  spec_start;
   logic              shuffle_on;
   logic [SPEC_W-1:0] special_sz;
   int                order_ix [MAX_SLOTS];
   page_answer_type   pending_answers [$];

   initial begin
      fail_count    = 0;
      pend_count    = 0;
      page_count    = 0;
      checked_count = 0;
      dir_written   = '0;
   end

   function automatic int align8(input int x);
      return (x + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
   endfunction

   function automatic int sat_page(input int x);
      return (x > PAGE_BYTES) ? PAGE_BYTES : x;
   endfunction

   function automatic int slots_in_use();
      int c;
      c = (int'(lower_b) - HEADER_BYTES) / SLOT_BYTES;
      return (c > MAX_SLOTS) ? MAX_SLOTS : c;
   endfunction

   // reserve room and fill a slot; returns the status code
   function automatic logic [STS_W-1:0] add_item(input int size, input int n_in,
                                                 input logic [FLAG_W-1:0] flg,
                                                 output int slot, output int offset);
      int  cnt, lim, n, newlow, asz, newup, i;
      bit  shifted;
      cnt     = slots_in_use();
      lim     = cnt + 1;
      n       = n_in;
      shifted = 0;
      slot    = 0;
      offset  = 0;
      if (n != 0) begin
         if (n > MAX_SLOTS) return STS_INVALID;
         if (shuffle_on) begin
            shifted = 1;
         end else if (dir[n-1].flags[0] || dir[n-1].len != 0) begin
            return STS_OVERWRITE;
         end
      end else begin
         for (n = 1; n < lim; n++)
            if (!dir[n-1].flags[0] && dir[n-1].len == 0) break;
      end
      if (n > lim) newlow = HEADER_BYTES + SLOT_BYTES * n;
      else if (n == lim || shifted) newlow = lower_b + SLOT_BYTES;
      else newlow = lower_b;
      asz = align8(size);
      if (asz > upper_b) return STS_NO_ROOM;
      newup = upper_b - asz;
      if (newlow > newup) return STS_NO_ROOM;
      if ((newlow - HEADER_BYTES) / SLOT_BYTES > MAX_SLOTS) return STS_NO_ROOM;
      // open a hole at slot n
      if (shifted && n < lim) begin
         for (i = cnt; i >= n; i--) begin
            dir[i] = dir[i-1];
            dir_written[i] = 1'b1;
         end
      end
      dir[n-1].off   = BND_W'(newup);
      dir[n-1].len   = SIZE_W'(size);
      dir[n-1].flags = flg;
      dir_written[n-1] = 1'b1;
      lower_b = BND_W'(newlow);
      upper_b = BND_W'(newup);
      slot    = n;
      offset  = newup;
      return STS_OK;
   endfunction

   // remove a slot, close the gap and move the lower items up
   function automatic logic [STS_W-1:0] delete_item(input int n);
      int cnt, sz, locn, i;
      cnt = slots_in_use();
      if (n == 0 || n > cnt) return STS_INVALID;
      sz   = align8(dir[n-1].len);
      locn = dir[n-1].off;
      for (i = n - 1; i + 1 < cnt; i++) dir[i] = dir[i+1];
      upper_b = BND_W'(sat_page(upper_b + sz));
      lower_b = lower_b - SLOT_BYTES;
      if (lower_b > HEADER_BYTES) begin
         for (i = 0; i + 1 < cnt; i++)
            if (dir[i].off <= locn) dir[i].off = BND_W'(sat_page(dir[i].off + sz));
      end
      return STS_OK;
   endfunction

   // repack used items by descending offset, lower slot first on ties
   function automatic void compact_page();
      int cnt, nused, i, j, up, a;
      cnt   = slots_in_use();
      nused = 0;
      for (i = 0; i < cnt; i++) begin
         if (dir[i].flags[0]) begin
            j = nused;
            while (j > 0 && dir[order_ix[j-1]].off < dir[i].off) begin
               order_ix[j] = order_ix[j-1];
               j--;
            end
            order_ix[j] = i;
            nused++;
         end else begin
            dir[i].len = '0;
         end
      end
      up = spec_start;
      for (i = 0; i < nused; i++) begin
         a  = align8(dir[order_ix[i]].len);
         up = (a > up) ? 0 : up - a;
         dir[order_ix[i]].off = BND_W'(up);
      end
      upper_b = BND_W'(up);
   endfunction

   function automatic page_answer_type predict_page_op(input logic [2:0] act,
                                                       input int size, input int n,
                                                       input logic [FLAG_W-1:0] flg);
      page_answer_type r;
      int              slot, offset, sp, fb;
      slot     = 0;
      offset   = 0;
      r.status = STS_OK;
      case (act)
         ACT_INIT: begin
            sp = align8(special_sz);
            if (sp > (PAGE_BYTES - HEADER_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES)
               sp = (PAGE_BYTES - HEADER_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
            lower_b    = HEADER_BYTES;
            upper_b    = BND_W'(PAGE_BYTES - sp);
            spec_start = BND_W'(PAGE_BYTES - sp);
         end
         ACT_ADD:     r.status = add_item(size, n, flg, slot, offset);
         ACT_DELETE:  r.status = delete_item(n);
         ACT_COMPACT: compact_page();
         default: ;
      endcase
      fb       = (upper_b >= lower_b + SLOT_BYTES) ? upper_b - lower_b - SLOT_BYTES : 0;
      r.slot   = SLOT_W'(slot);
      r.offset = OFF_W'(offset);
      r.free   = FREE_W'(fb);
      r.count  = SLOT_W'(slots_in_use());
      return r;
   endfunction

   always @(posedge clock) begin
      page_answer_type got;
      page_answer_type want;
      if (reset) begin
         lower_b    = HEADER_BYTES;
         upper_b    = PAGE_BYTES;
         spec_start = PAGE_BYTES;
         shuffle_on = 1'b1;
         special_sz = '0;
         pending_answers.delete();
      end else begin
         // track register writes
         if (csr_we) begin
            case (csr_index)
               REG_SHUFFLE: shuffle_on = csr_wdata[0];
               REG_SPECIAL: special_sz = csr_wdata;
               default: ;
            endcase
         end
         // compare a result beat with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.slot   = rsp_tdata[10:0];
            got.offset = rsp_tdata[23:11];
            got.free   = rsp_tdata[37:24];
            got.count  = rsp_tdata[48:38];
            checked_count++;
            if (pending_answers.size() == 0) begin
               $error("result beat with no prediction waiting");
               fail_count++;
            end else begin
               want = pending_answers.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.slot !== want.slot) begin
                  $error("result_slot: expected %0d, got %0d", want.slot, got.slot);
                  fail_count++;
               end
               if (got.offset !== want.offset) begin
                  $error("item_offset: expected %0d, got %0d", want.offset, got.offset);
                  fail_count++;
               end
               if (got.free !== want.free) begin
                  $error("free_bytes: expected %0d, got %0d", want.free, got.free);
                  fail_count++;
               end
               if (got.count !== want.count) begin
                  $error("slot_count: expected %0d, got %0d", want.count, got.count);
                  fail_count++;
               end
            end
         end
         // predict each accepted request beat
         if (req_tvalid && req_tready)
            pending_answers.push_back(predict_page_op(req_tuser, int'(req_tdata[13:0]),
                                                      int'(req_tdata[24:14]),
                                                      req_tdata[26:25]));
      end
      pend_count = pending_answers.size();
      page_count = slots_in_use();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives init, add, delete, compact and query beats into the slotted page
// directory under several register settings and random stalls on both
// channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
   import spd_pkg::*;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 csr_we     = 1'b0;
   logic [IDX_W-1:0]     csr_index  = '0;
   logic [SPEC_W-1:0]    csr_wdata  = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;
   logic [2:0]           req_tuser  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [55:0]          rsp_tdata;
   logic [1:0]           rsp_tuser;

   int                   fail_count, pend_count, page_count, checked_count;
   logic [MAX_SLOTS-1:0] dir_written;
   int                   send_idle = 0;
   int                   recv_idle = 0;
   int                   sent_count = 0;
   logic                 cur_shuffle = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   slotted_page_directory i_dut (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   page_directory_checker i_checker (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .fail_count, .pend_count, .page_count, .checked_count, .dir_written
   );

   // random back-pressure on the result channel
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle);

   task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= SPEC_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      if (idx == REG_SHUFFLE) cur_shuffle = value[0];
   endtask

   // send one beat, then hold until its result has been taken
   task automatic send_op(input logic [2:0] act, input int size, input int n,
                          input int flg);
      while ($urandom_range(99) < send_idle) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {5'd0, FLAG_W'(flg), SLOT_W'(n), SIZE_W'(size)};
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
      sent_count++;
      do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
   endtask

   task automatic send_random();
      int r, act, size, n, flg, cnt, hi, j;
      cnt = page_count;
      r   = $urandom_range(99);
      if (r < 48) act = ACT_ADD;
      else if (r < 72) act = ACT_DELETE;
      else if (r < 82) act = ACT_COMPACT;
      else if (r < 88) act = ACT_QUERY;
      else if (r < 94) act = ACT_INIT;
      else act = $urandom_range(7, 5);
      // mostly small items, a few huge ones
      r = $urandom_range(99);
      if (r < 60) size = $urandom_range(64);
      else if (r < 85) size = $urandom_range(600, 65);
      else if (r < 95) size = $urandom_range(16383);
      else size = 8192;
      flg = ($urandom_range(99) < 80) ? ($urandom_range(3) | 1) : $urandom_range(3);
      n   = 0;
      if (act == ACT_ADD) begin
         r = $urandom_range(99);
         if (r < 40) n = 0;
         else if (r < 75) n = $urandom_range(cnt + 1, 1);
         else if (r < 92) n = $urandom_range((cnt + 40 > 2047) ? 2047 : cnt + 40, cnt + 1);
         else n = $urandom_range(2047, 1024);
         // never touch a directory entry that holds no data yet
         if (n > cnt) begin
            hi = cur_shuffle ? n - 1 : n;
            for (j = cnt + 1; j <= hi; j++)
               if (!dir_written[j-1]) n = 0;
         end
      end else if (act == ACT_DELETE) begin
         n = (cnt > 0 && $urandom_range(99) < 70) ? $urandom_range(cnt, 1)
                                                  : $urandom_range(2047);
      end else begin
         n = $urandom_range(2047);
      end
      send_op(3'(act), size, n, flg);
   endtask

   initial begin
      int p;
      int shuffle_set [6] = '{0, 1, 0, 1, 0, 1};
      int special_set [6] = '{8176, 0, 100, 8000, 0, 37};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty page, page-end item, no room, shuffle insert, deletes
      send_op(ACT_QUERY, 0, 0, 0);
      send_op(ACT_ADD, 0, 0, 1);
      send_op(ACT_ADD, 13, 0, 1);
      send_op(ACT_ADD, 100, 1, 3);
      send_op(ACT_ADD, 16383, 0, 1);
      send_op(ACT_ADD, 8192, 0, 1);
      send_op(ACT_ADD, 8, 4, 1);
      send_op(ACT_DELETE, 0, 0, 0);
      send_op(ACT_DELETE, 0, 2047, 0);
      send_op(ACT_DELETE, 0, 2, 0);
      send_op(ACT_ADD, 5, 0, 2);
      send_op(ACT_COMPACT, 0, 0, 0);
      send_op(ACT_ADD, 24, 0, 1);
      send_op(3'd5, 0, 0, 0);
      send_op(3'd7, 16383, 2047, 3);
      // overwrite mode: used slot rejected
      write_reg(REG_SHUFFLE, 0);
      send_op(ACT_ADD, 4, 1, 1);
      send_op(ACT_DELETE, 0, 1, 0);
      send_op(ACT_COMPACT, 0, 0, 0);
      // largest special area that init allows, right at the clamp limit
      write_reg(REG_SPECIAL, 8176);
      send_op(ACT_INIT, 0, 0, 0);
      send_op(ACT_ADD, 16, 0, 1);
      send_op(ACT_ADD, 0, 0, 1);
      send_op(ACT_COMPACT, 0, 0, 0);

      // random phases under several register settings
      for (p = 0; p < 6; p++) begin
         if (p < 2) begin
            send_idle = 20;
            recv_idle = 82;
         end else if (p < 4) begin
            send_idle = 82;
            recv_idle = 20;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_reg(REG_SHUFFLE, shuffle_set[p]);
         write_reg(REG_SPECIAL, special_set[p]);
         send_op(ACT_INIT, 0, 0, 0);
         repeat (44) send_random();
      end

      do @(posedge clock); while (pend_count != 0);
      repeat (20) @(posedge clock);
      $display("Sent %0d beats over six register settings; %0d results compared.",
               sent_count, checked_count);
      if (fail_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
